@@ rtl/rfp_pkg.sv @@
// Package for the radix-50 file name packer.
// Holds field widths, status codes and the character-to-digit and padding functions.
// No dependencies.
package rfp_pkg;

  localparam int CHAR_W   = 8;
  localparam int WORD_W   = 16;
  localparam int STATUS_W = 2;
  localparam int DIGIT_W  = 6;

  typedef logic [CHAR_W-1:0]   char_t;
  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [DIGIT_W-1:0]  digit_t;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_BAD   = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  localparam char_t CH_NUL    = 8'h00;
  localparam char_t CH_DOT    = 8'h2e;
  localparam char_t CH_DOLLAR = 8'h24;
  localparam char_t CH_UNDER  = 8'h5f;

  localparam digit_t DIG_DOLLAR = 6'd27;
  localparam digit_t DIG_DOT    = 6'd28;
  localparam digit_t DIG_UNDER  = 6'd29;
  localparam digit_t DIG_ZERO   = 6'd30;

  localparam word_t RADIX = 16'd40;

  // Maps a character to its radix-50 digit. Zero means the character is invalid;
  // space maps to zero as well, so it is rejected too.
  function automatic digit_t digit_of(char_t c);
    char_t u;
    digit_t d;
    u = c;
    if (c >= 8'h61 && c <= 8'h7a) begin
      u = c - 8'd32;
    end
    d = '0;
    if (u >= 8'h41 && u <= 8'h5a) begin
      d = DIGIT_W'(u - 8'h40);
    end else if (u == CH_DOLLAR) begin
      d = DIG_DOLLAR;
    end else if (u == CH_DOT) begin
      d = DIG_DOT;
    end else if (u == CH_UNDER) begin
      d = DIG_UNDER;
    end else if (u >= 8'h30 && u <= 8'h39) begin
      d = DIGIT_W'(u - 8'h30) + DIG_ZERO;
    end
    return d;
  endfunction

  // Shifts one more base-40 digit into a word.
  function automatic word_t push_digit(word_t acc, digit_t d);
    return WORD_W'(acc * RADIX) + WORD_W'(d);
  endfunction

  // Fills the digits that were not taken with zero.
  function automatic word_t pad_word(word_t acc, logic [1:0] taken);
    word_t r;
    unique case (taken)
      2'd0: r = WORD_W'(acc * 16'd64000);
      2'd1: r = WORD_W'(acc * 16'd1600);
      2'd2: r = WORD_W'(acc * RADIX);
      default: r = acc;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/rfp_char_if.sv @@
// Character channel of the radix-50 file name packer.
// Depends on rfp_pkg.
interface rfp_char_if import rfp_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t character;

  modport source (output valid, output character, input ready);
  modport sink (input valid, input character, output ready);
endinterface

@@ rtl/rfp_result_if.sv @@
// Result channel of the radix-50 file name packer: three packed words and a status.
// Depends on rfp_pkg.
interface rfp_result_if import rfp_pkg::*; ();
  logic    valid;
  logic    ready;
  word_t   name_first_word;
  word_t   name_second_word;
  word_t   extension_word;
  status_t parse_status;

  modport source (output valid, output name_first_word, output name_second_word,
                  output extension_word, output parse_status, input ready);
  modport sink (input valid, input name_first_word, input name_second_word,
                input extension_word, input parse_status, output ready);
endinterface

@@ rtl/radix50_filename_packer.sv @@
// Top level of the radix-50 file name packer.
// Depends on rfp_pkg, rfp_char_if and rfp_result_if.
//
//   channel  | direction | request payload
//   ---------+-----------+------------------------------------------------------
//   chars    | in        | character (8 bits, 0 ends the string)
//   result   | out       | name_first_word, name_second_word, extension_word,
//            |           | parse_status
//
// One character is taken per cycle; the parse state and, when a decision is
// reached, the output register are both written at the accepting edge, so a
// result is offered in the cycle after the character that caused it.
// The only limit on rate is the single output register: a character is refused
// only while a result sits there and the sink is not taking it.
// Reset (synchronous) returns to the name phase with the word accumulators cleared.
module radix50_filename_packer
  import rfp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  rfp_char_if.sink      chars,
  rfp_result_if.source  result
);

  localparam logic [1:0] PH_NAME   = 2'd0;
  localparam logic [1:0] PH_SKIP   = 2'd1;
  localparam logic [1:0] PH_EXT    = 2'd2;
  localparam logic [1:0] PH_IGNORE = 2'd3;

  logic [1:0] phase, phase_next;
  logic [2:0] pos, pos_next;
  word_t      first_acc, first_acc_next;
  word_t      second_acc, second_acc_next;
  word_t      ext_acc, ext_acc_next;

  logic    out_valid;
  word_t   out_first, out_second, out_ext;
  status_t out_status;

  logic    accept;
  logic    emit;
  status_t emit_status;
  word_t   emit_first, emit_second, emit_ext;

  char_t  c;
  digit_t d;
  logic   is_nul, is_dot;
  word_t  first_pad, second_pad, ext_pad, ext_push;

  assign c      = chars.character;
  assign d      = digit_of(c);
  assign is_nul = (c == CH_NUL);
  assign is_dot = (c == CH_DOT);

  assign chars.ready = !out_valid || result.ready;
  assign accept      = chars.valid && chars.ready;

  assign first_pad  = pad_word(first_acc, (pos > 3'd3) ? 2'd3 : pos[1:0]);
  assign second_pad = pad_word(second_acc, (pos > 3'd3) ? 2'(pos - 3'd3) : 2'd0);
  assign ext_pad    = pad_word(ext_acc, pos[1:0]);
  assign ext_push   = push_digit(ext_acc, d);

  always_comb begin
    phase_next      = phase;
    pos_next        = pos;
    first_acc_next  = first_acc;
    second_acc_next = second_acc;
    ext_acc_next    = ext_acc;
    emit            = 1'b0;
    emit_status     = ST_OK;
    emit_first      = '0;
    emit_second     = '0;
    emit_ext        = '0;

    unique case (phase)
      PH_IGNORE: begin
        if (is_nul) begin
          phase_next      = PH_NAME;
          pos_next        = '0;
          first_acc_next  = '0;
          second_acc_next = '0;
          ext_acc_next    = '0;
        end
      end
      PH_SKIP: begin
        if (is_nul) begin
          emit            = 1'b1;
          emit_first      = first_acc;
          emit_second     = second_acc;
          emit_ext        = ext_acc;
          phase_next      = PH_NAME;
          pos_next        = '0;
          first_acc_next  = '0;
          second_acc_next = '0;
          ext_acc_next    = '0;
        end else if (is_dot) begin
          phase_next = PH_EXT;
          pos_next   = '0;
        end
      end
      PH_EXT: begin
        if (is_nul) begin
          emit            = 1'b1;
          emit_first      = first_acc;
          emit_second     = second_acc;
          emit_ext        = ext_pad;
          phase_next      = PH_NAME;
          pos_next        = '0;
          first_acc_next  = '0;
          second_acc_next = '0;
          ext_acc_next    = '0;
        end else if (d == '0) begin
          emit        = 1'b1;
          emit_status = ST_BAD;
          phase_next  = PH_IGNORE;
        end else begin
          ext_acc_next = ext_push;
          if (pos == 3'd2) begin
            // Third extension character completes the name at once.
            emit        = 1'b1;
            emit_first  = first_acc;
            emit_second = second_acc;
            emit_ext    = ext_push;
            phase_next  = PH_IGNORE;
          end else begin
            pos_next = pos + 3'd1;
          end
        end
      end
      default: begin
        if (is_nul || is_dot) begin
          if (pos == '0) begin
            emit        = 1'b1;
            emit_status = ST_EMPTY;
            phase_next  = is_nul ? PH_NAME : PH_IGNORE;
          end else if (is_nul) begin
            emit            = 1'b1;
            emit_first      = first_pad;
            emit_second     = second_pad;
            emit_ext        = ext_acc;
            phase_next      = PH_NAME;
            pos_next        = '0;
            first_acc_next  = '0;
            second_acc_next = '0;
            ext_acc_next    = '0;
          end else begin
            first_acc_next  = first_pad;
            second_acc_next = second_pad;
            phase_next      = PH_EXT;
            pos_next        = '0;
          end
        end else if (d == '0) begin
          emit        = 1'b1;
          emit_status = ST_BAD;
          phase_next  = PH_IGNORE;
        end else begin
          if (pos < 3'd3) begin
            first_acc_next = push_digit(first_acc, d);
          end else begin
            second_acc_next = push_digit(second_acc, d);
          end
          if (pos == 3'd5) begin
            phase_next = PH_SKIP;
            pos_next   = '0;
          end else begin
            pos_next = pos + 3'd1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_NAME;
      pos        <= '0;
      first_acc  <= '0;
      second_acc <= '0;
      ext_acc    <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      pos        <= pos_next;
      first_acc  <= first_acc_next;
      second_acc <= second_acc_next;
      ext_acc    <= ext_acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_first  <= emit_first;
      out_second <= emit_second;
      out_ext    <= emit_ext;
      out_status <= emit_status;
    end
  end

  assign result.valid            = out_valid;
  assign result.name_first_word  = out_first;
  assign result.name_second_word = out_second;
  assign result.extension_word   = out_ext;
  assign result.parse_status     = out_status;

endmodule

@@ test/tb_top.sv @@
// Testbench for the radix-50 file name packer: random and directed file names,
// checked against a behavioral predictor of the packer kept in this file.
// Depends on rfp_pkg, rfp_char_if, rfp_result_if and radix50_filename_packer.
`timescale 1ns / 1ps

module tb_top;
  import rfp_pkg::*;

  typedef enum logic [2:0] {
    PHASE_NAME,
    PHASE_SKIP,
    PHASE_EXT,
    PHASE_IGNORE
  } phase_t;

  typedef struct packed {
    word_t   first_word;
    word_t   second_word;
    word_t   ext_word;
    status_t status;
  } packed_name_t;

  localparam int BASE = 40;
  localparam int RANDOM_CHARS = 1900;
  localparam int STEADY_START = 1500;
  localparam int STEADY_END = 2300;

  // Empty names, lower case, skipped name characters, a dot inside the
  // extension, a space, an upper code and a full extension before the end.
  localparam char_t OPENING [24] = '{
    CH_NUL,
    CH_DOT, CH_NUL,
    "z", "9", CH_DOLLAR, CH_UNDER, "A", "b", "Q", CH_DOT, CH_DOT, "9", CH_NUL,
    " ", CH_NUL,
    8'hff, CH_NUL,
    "X", CH_DOT, "a", "b", CH_UNDER, CH_NUL
  };

  logic clk;
  logic rst;

  rfp_char_if chars ();
  rfp_result_if result ();

  radix50_filename_packer uut (
    .clk(clk),
    .rst(rst),
    .chars(chars),
    .result(result)
  );

  char_t        char_queue [$];
  packed_name_t expected_packs [$];
  int           chars_total;
  int           chars_accepted = 0;
  int           cycle_count = 0;
  int           errors = 0;
  logic         char_taken = 1'b0;

  // Predictor state.
  phase_t parse_phase = PHASE_NAME;
  int     taken = 0;
  word_t  acc_first = '0;
  word_t  acc_second = '0;
  word_t  acc_ext = '0;

  function automatic digit_t radix_digit(char_t c);
    char_t up;
    up = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    if (up >= "A" && up <= "Z") return digit_t'(up - "A" + 8'd1);
    if (up == CH_DOLLAR) return DIG_DOLLAR;
    if (up == CH_DOT) return DIG_DOT;
    if (up == CH_UNDER) return DIG_UNDER;
    if (up >= "0" && up <= "9") return digit_t'(up - "0") + DIG_ZERO;
    return '0;
  endfunction

  function automatic word_t shift_in(word_t acc, digit_t d);
    return word_t'(int'(acc) * BASE + int'(d));
  endfunction

  function automatic word_t zero_fill(word_t acc, int used);
    for (int i = used; i < 3; i++) begin
      acc = word_t'(int'(acc) * BASE);
    end
    return acc;
  endfunction

  function automatic packed_name_t make_pack(status_t st, bit with_words);
    packed_name_t r;
    r = '0;
    if (with_words) begin
      r.first_word = acc_first;
      r.second_word = acc_second;
      r.ext_word = acc_ext;
    end
    r.status = st;
    return r;
  endfunction

  function automatic void start_name();
    parse_phase = PHASE_NAME;
    taken = 0;
    acc_first = '0;
    acc_second = '0;
    acc_ext = '0;
  endfunction

  // Advances the predictor by one character and queues the result it causes.
  function automatic void pack_char(char_t c);
    digit_t d;
    d = radix_digit(c);
    case (parse_phase)
      PHASE_IGNORE: begin
        if (c == CH_NUL) start_name();
      end
      PHASE_SKIP: begin
        if (c == CH_NUL) begin
          expected_packs.push_back(make_pack(ST_OK, 1'b1));
          start_name();
        end else if (c == CH_DOT) begin
          parse_phase = PHASE_EXT;
          taken = 0;
        end
      end
      PHASE_EXT: begin
        if (c == CH_NUL) begin
          acc_ext = zero_fill(acc_ext, taken);
          expected_packs.push_back(make_pack(ST_OK, 1'b1));
          start_name();
        end else if (d == '0) begin
          expected_packs.push_back(make_pack(ST_BAD, 1'b0));
          parse_phase = PHASE_IGNORE;
        end else begin
          acc_ext = shift_in(acc_ext, d);
          taken++;
          if (taken == 3) begin
            expected_packs.push_back(make_pack(ST_OK, 1'b1));
            parse_phase = PHASE_IGNORE;
          end
        end
      end
      default: begin
        if (c == CH_NUL || c == CH_DOT) begin
          if (taken == 0) begin
            expected_packs.push_back(make_pack(ST_EMPTY, 1'b0));
            if (c == CH_NUL) start_name();
            else parse_phase = PHASE_IGNORE;
          end else begin
            acc_first = zero_fill(acc_first, taken > 3 ? 3 : taken);
            acc_second = zero_fill(acc_second, taken > 3 ? taken - 3 : 0);
            if (c == CH_NUL) begin
              expected_packs.push_back(make_pack(ST_OK, 1'b1));
              start_name();
            end else begin
              parse_phase = PHASE_EXT;
              taken = 0;
            end
          end
        end else if (d == '0) begin
          expected_packs.push_back(make_pack(ST_BAD, 1'b0));
          parse_phase = PHASE_IGNORE;
        end else begin
          if (taken < 3) acc_first = shift_in(acc_first, d);
          else acc_second = shift_in(acc_second, d);
          taken++;
          if (taken == 6) begin
            parse_phase = PHASE_SKIP;
            taken = 0;
          end
        end
      end
    endcase
  endfunction

  function automatic char_t legal_char(bit allow_dot);
    case ($urandom_range(0, allow_dot ? 5 : 4))
      0: return char_t'($urandom_range(8'h41, 8'h5a));
      1: return char_t'($urandom_range(8'h61, 8'h7a));
      2: return char_t'($urandom_range(8'h30, 8'h39));
      3: return CH_DOLLAR;
      4: return CH_UNDER;
      default: return CH_DOT;
    endcase
  endfunction

  function automatic char_t illegal_char();
    char_t c;
    do begin
      c = char_t'($urandom_range(1, 255));
    end while (radix_digit(c) != '0);
    return c;
  endfunction

  function automatic bit take_break();
    return !(cycle_count >= STEADY_START && cycle_count < STEADY_END) &&
           $urandom_range(0, 99) < 35;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Request driver and ready generator.
  always @(negedge clk) begin
    if (rst) begin
      chars.valid <= 1'b0;
      result.ready <= 1'b0;
    end else begin
      result.ready <= !take_break();
      if (!chars.valid || char_taken) begin
        if (char_queue.size() != 0 && !take_break()) begin
          chars.valid <= 1'b1;
          chars.character <= char_queue.pop_front();
        end else begin
          chars.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: results are checked before the character taken at the same edge
  // is predicted, since that character cannot have produced them.
  always @(posedge clk) begin
    packed_name_t want;
    cycle_count <= cycle_count + 1;
    char_taken <= !rst && chars.valid && chars.ready;
    if (!rst) begin
      if (result.valid && result.ready) begin
        if (expected_packs.size() == 0) begin
          $error("result with no request pending: status %0d", result.parse_status);
          errors++;
        end else begin
          want = expected_packs.pop_front();
          check_field("name_first_word", want.first_word, result.name_first_word);
          check_field("name_second_word", want.second_word, result.name_second_word);
          check_field("extension_word", want.ext_word, result.extension_word);
          check_field("parse_status", want.status, result.parse_status);
        end
      end
      if (chars.valid && chars.ready) begin
        pack_char(chars.character);
        chars_accepted <= chars_accepted + 1;
      end
    end
  end

  initial begin
    char_t one_name [$];
    int    name_len;
    int    ext_len;
    int    kind;
    rst = 1'b1;

    foreach (OPENING[i]) char_queue.push_back(OPENING[i]);

    while (char_queue.size() < RANDOM_CHARS) begin
      one_name.delete();
      kind = $urandom_range(0, 99);
      if (kind < 90) begin
        name_len = $urandom_range(0, 8);
        for (int i = 0; i < name_len; i++) begin
          // Past six characters anything but a dot or the end is skipped.
          if (i >= 6 && $urandom_range(0, 1)) begin
            do one_name.push_back(char_t'($urandom_range(1, 255)));
            while (one_name[$] == CH_DOT);
          end else begin
            one_name.push_back(legal_char(1'b0));
          end
        end
        if ($urandom_range(0, 2) != 0) begin
          one_name.push_back(CH_DOT);
          ext_len = $urandom_range(0, 4);
          for (int i = 0; i < ext_len; i++) one_name.push_back(legal_char(1'b1));
        end
        if (kind >= 75 && one_name.size() != 0) begin
          one_name[$urandom_range(0, one_name.size() - 1)] = illegal_char();
        end
      end else begin
        name_len = $urandom_range(1, 10);
        for (int i = 0; i < name_len; i++) begin
          one_name.push_back(char_t'($urandom_range(0, 255)));
        end
      end
      one_name.push_back(CH_NUL);
      foreach (one_name[i]) char_queue.push_back(one_name[i]);
    end
    chars_total = char_queue.size();

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (chars_accepted != chars_total || expected_packs.size() != 0);
    repeat (20) @(posedge clk);

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/rfp_pkg.sv
rtl/rfp_char_if.sv
rtl/rfp_result_if.sv
rtl/radix50_filename_packer.sv
test/tb_top.sv
